[rtl/sssp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants of the shortest path unit
// Word layouts, table sizes and request/status codes.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int HEAP_DEPTH   = MAX_EDGES + 1;

    localparam int VTX_W    = $clog2(MAX_VERTICES);
    localparam int EIDX_W   = $clog2(MAX_EDGES);
    localparam int LINK_W   = EIDX_W + 1;
    localparam int HIDX_W   = $clog2(HEAP_DEPTH);
    localparam int CNT_W    = VTX_W + 1;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 30;

    localparam logic [DIST_W-1:0] UNREACHED = 30'd1000000000;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic CFG_VERTEX_COUNT  = 1'b0;
    localparam logic CFG_REVERSE_EDGES = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [VTX_W-1:0]    vertex_a;
        logic [VTX_W-1:0]    vertex_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DIST_W-1:0] distance;
    } rsp_t;

    typedef struct packed {
        logic [VTX_W-1:0]    target;
        logic [WEIGHT_W-1:0] cost;
        logic [LINK_W-1:0]   next;
    } edge_t;

    typedef struct packed {
        logic [DIST_W-1:0] key;
        logic [VTX_W-1:0]  vertex;
    } heap_entry_t;

    typedef struct packed {
        logic              lt;
        logic              eq;
        logic [DIST_W-1:0] sum;
    } alu_res_t;

endpackage
`default_nettype wire

[rtl/sssp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sssp_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sssp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/sssp_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sssp_alu: shared distance arithmetic
// Saturating add, less-than and equality on two distance operands.
// ----------------------------------------------------------------------------
module sssp_alu (
    input  wire logic [sssp_pkg::DIST_W-1:0] opa,
    input  wire logic [sssp_pkg::DIST_W-1:0] opb,
    output sssp_pkg::alu_res_t               res
);
    import sssp_pkg::*;

    logic [DIST_W:0] raw_sum;

    always_comb
    begin
        raw_sum = {1'b0, opa} + {1'b0, opb};
        res.lt  = opa < opb;
        res.eq  = opa == opb;
        // clamp at the unreached mark
        res.sum = (raw_sum > {1'b0, UNREACHED}) ? UNREACHED : raw_sum[DIST_W-1:0];
    end

endmodule
`default_nettype wire

[rtl/single_source_shortest_path_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// single_source_shortest_path_unit: graph store with Dijkstra shortest paths
// Adjacency-list edge table, binary min-heap and one shared distance ALU.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one word per request: add
//   edge, run from source, query distance or clear graph. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one status/distance word per
//   request, in order. Configuration (vertex count, edge reversal) is written
//   through cfg_we/cfg_index/cfg_data while the unit is idle.
// Timing:
//   One request at a time; req_ready is low from acceptance until the
//   response word has been taken. Clear sweeps the head table. Run first
//   presets all distances, then pops the heap with a sift-down per pop and
//   relaxes each edge, with a sift-up per improved distance; the single read
//   port of the heap RAM and the shared ALU set the pace.
// Reset:
//   After rst_n the unit sweeps the head and distance tables with req_ready
//   low; configuration writes are taken during the sweep.
// Stall:
//   A stalled response holds in the output register; no new request is taken.
// ----------------------------------------------------------------------------
module single_source_shortest_path_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire sssp_pkg::req_t        req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output sssp_pkg::rsp_t             rsp,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [sssp_pkg::CNT_W-1:0] cfg_data
);
    import sssp_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ADD, S_QRY, S_GCLR, S_RCLR, S_RSEED,
        S_POP, S_POP1, S_POP2, S_SD, S_SDL, S_SDR,
        S_CHK, S_CHK1, S_CHK2, S_EDGE, S_E1, S_E2, S_SU, S_SU1
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  vcount_reg, vcount_next;
    logic              rev_reg, rev_next;
    logic [LINK_W-1:0] efill_reg, efill_next;
    logic [HIDX_W-1:0] hfill_reg, hfill_next;
    logic [VTX_W-1:0]  sweep_reg, sweep_next;
    req_t              cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;
    logic [1:0]        run_status_reg, run_status_next;
    logic [DIST_W-1:0] cost_reg, cost_next;
    logic [VTX_W-1:0]  u_reg, u_next;
    heap_entry_t       x_reg, x_next;
    logic [HIDX_W-1:0] idx_reg, idx_next;
    heap_entry_t       lent_reg, lent_next;
    logic              llt_reg, llt_next;
    logic [LINK_W-1:0] link_reg, link_next;
    logic [DIST_W-1:0] sum_reg, sum_next;
    logic [VTX_W-1:0]  v_reg, v_next;
    logic [HIDX_W-1:0] par_reg, par_next;

    // memory ports
    logic              head_we;
    logic [VTX_W-1:0]  head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata, head_rdata;
    logic              edge_we;
    logic [EIDX_W-1:0] edge_waddr, edge_raddr;
    edge_t             edge_wdata, edge_rdata;
    logic              dist_we;
    logic [VTX_W-1:0]  dist_waddr, dist_raddr;
    logic [DIST_W-1:0] dist_wdata, dist_rdata;
    logic              heap_we;
    logic [HIDX_W-1:0] heap_waddr, heap_raddr;
    heap_entry_t       heap_wdata, heap_rdata;

    logic [DIST_W-1:0] alu_a, alu_b;
    alu_res_t          alu_res;

    logic [CNT_W-1:0]  nvert;
    logic              accept;
    logic              a_bad, b_bad;
    logic [VTX_W-1:0]  add_tail, add_head;
    logic [HIDX_W:0]   lidx, ridx;
    heap_entry_t       best;

    sssp_ram #(.WIDTH(LINK_W), .DEPTH(MAX_VERTICES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    sssp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    sssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist (
        .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_rdata)
    );

    sssp_ram #(.WIDTH($bits(heap_entry_t)), .DEPTH(HEAP_DEPTH)) u_heap (
        .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    sssp_alu u_alu (
        .opa(alu_a),
        .opb(alu_b),
        .res(alu_res)
    );

    assign req_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign accept    = req_valid && req_ready;

    // active vertex count, clamped to the table size
    assign nvert = (vcount_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_reg;
    assign a_bad = {1'b0, req.vertex_a} >= nvert;
    assign b_bad = {1'b0, req.vertex_b} >= nvert;
    assign add_tail = rev_reg ? cur_reg.vertex_b : cur_reg.vertex_a;
    assign add_head = rev_reg ? cur_reg.vertex_a : cur_reg.vertex_b;
    assign lidx = {idx_reg, 1'b1};
    assign ridx = lidx + (HIDX_W+1)'(1);
    assign best = llt_reg ? lent_reg : x_reg;

    always_comb
    begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        rev_next        = rev_reg;
        efill_next      = efill_reg;
        hfill_next      = hfill_reg;
        sweep_next      = sweep_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        run_status_next = run_status_reg;
        cost_next       = cost_reg;
        u_next          = u_reg;
        x_next          = x_reg;
        idx_next        = idx_reg;
        lent_next       = lent_reg;
        llt_next        = llt_reg;
        link_next       = link_reg;
        sum_next        = sum_reg;
        v_next          = v_reg;
        par_next        = par_reg;

        head_we    = 1'b0;
        head_waddr = sweep_reg;
        head_wdata = '0;
        head_raddr = u_reg;
        edge_we    = 1'b0;
        edge_waddr = efill_reg[EIDX_W-1:0];
        edge_wdata = '{target: add_head, cost: cur_reg.edge_weight, next: head_rdata};
        edge_raddr = EIDX_W'(link_reg - LINK_W'(1));
        dist_we    = 1'b0;
        dist_waddr = sweep_reg;
        dist_wdata = UNREACHED;
        dist_raddr = u_reg;
        heap_we    = 1'b0;
        heap_waddr = idx_reg;
        heap_wdata = x_reg;
        heap_raddr = '0;
        alu_a      = '0;
        alu_b      = '0;

        // drop the response word once taken
        if (rsp_valid && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT:  vcount_next = cfg_data;
                CFG_REVERSE_EDGES: rev_next    = cfg_data[0];
                default:           vcount_next = vcount_reg;
            endcase
        end

        case (state_reg)
            S_INIT:
            begin
                // preset head and distance tables after reset
                head_we = 1'b1;
                dist_we = 1'b1;
                sweep_next = sweep_reg + VTX_W'(1);
                if (&sweep_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next = req;
                    out_next = '{status: ST_OK, distance: '0};
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            head_raddr = rev_reg ? req.vertex_b : req.vertex_a;
                            if (a_bad || b_bad)
                            begin
                                out_next.status = ST_RANGE;
                                out_valid_next  = 1'b1;
                            end
                            else if (efill_reg >= LINK_W'(MAX_EDGES))
                            begin
                                out_next.status = ST_FULL;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        REQ_RUN:
                        begin
                            if (a_bad)
                            begin
                                out_next.status = ST_RANGE;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                run_status_next = ST_OK;
                                sweep_next      = '0;
                                state_next      = S_RCLR;
                            end
                        end
                        REQ_QUERY:
                        begin
                            dist_raddr = req.vertex_a;
                            if (a_bad)
                            begin
                                out_next.status = ST_RANGE;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_QRY;
                            end
                        end
                        default:
                        begin
                            sweep_next = '0;
                            state_next = S_GCLR;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                // link the new edge in front of the tail's list
                edge_we    = 1'b1;
                head_we    = 1'b1;
                head_waddr = add_tail;
                head_wdata = efill_reg + LINK_W'(1);
                efill_next = efill_reg + LINK_W'(1);
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_QRY:
            begin
                out_next.distance = dist_rdata;
                out_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end
            S_GCLR:
            begin
                head_we    = 1'b1;
                sweep_next = sweep_reg + VTX_W'(1);
                if (&sweep_reg)
                begin
                    efill_next     = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RCLR:
            begin
                dist_we    = 1'b1;
                sweep_next = sweep_reg + VTX_W'(1);
                if (&sweep_reg)
                begin
                    state_next = S_RSEED;
                end
            end
            S_RSEED:
            begin
                dist_we    = 1'b1;
                dist_waddr = cur_reg.vertex_a;
                dist_wdata = '0;
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = '{key: '0, vertex: cur_reg.vertex_a};
                hfill_next = HIDX_W'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (hfill_reg == '0)
                begin
                    out_next       = '{status: run_status_reg, distance: '0};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    heap_raddr = '0;
                    state_next = S_POP1;
                end
            end
            S_POP1:
            begin
                cost_next  = heap_rdata.key;
                u_next     = heap_rdata.vertex;
                heap_raddr = hfill_reg - HIDX_W'(1);
                hfill_next = hfill_reg - HIDX_W'(1);
                state_next = S_POP2;
            end
            S_POP2:
            begin
                // last entry fills the root hole and sifts down
                x_next     = heap_rdata;
                idx_next   = '0;
                state_next = S_SD;
            end
            S_SD:
            begin
                heap_raddr = lidx[HIDX_W-1:0];
                if (lidx >= {1'b0, hfill_reg})
                begin
                    heap_we    = 1'b1;
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_SDL;
                end
            end
            S_SDL:
            begin
                alu_a      = heap_rdata.key;
                alu_b      = x_reg.key;
                lent_next  = heap_rdata;
                llt_next   = alu_res.lt;
                heap_raddr = ridx[HIDX_W-1:0];
                if (ridx < {1'b0, hfill_reg})
                begin
                    state_next = S_SDR;
                end
                else if (alu_res.lt)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    idx_next   = lidx[HIDX_W-1:0];
                    state_next = S_SD;
                end
                else
                begin
                    heap_we    = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_SDR:
            begin
                alu_a   = heap_rdata.key;
                alu_b   = best.key;
                heap_we = 1'b1;
                if (alu_res.lt)
                begin
                    heap_wdata = heap_rdata;
                    idx_next   = ridx[HIDX_W-1:0];
                    state_next = S_SD;
                end
                else if (llt_reg)
                begin
                    heap_wdata = lent_reg;
                    idx_next   = lidx[HIDX_W-1:0];
                    state_next = S_SD;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                dist_raddr = u_reg;
                state_next = S_CHK1;
            end
            S_CHK1:
            begin
                // skip stale heap entries
                alu_a      = dist_rdata;
                alu_b      = cost_reg;
                head_raddr = u_reg;
                state_next = alu_res.eq ? S_CHK2 : S_POP;
            end
            S_CHK2:
            begin
                link_next  = head_rdata;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                state_next = (link_reg == '0) ? S_POP : S_E1;
            end
            S_E1:
            begin
                alu_a      = cost_reg;
                alu_b      = DIST_W'(edge_rdata.cost);
                link_next  = edge_rdata.next;
                v_next     = edge_rdata.target;
                sum_next   = alu_res.sum;
                dist_raddr = edge_rdata.target;
                if ({1'b0, edge_rdata.target} >= nvert)
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    state_next = S_E2;
                end
            end
            S_E2:
            begin
                alu_a = sum_reg;
                alu_b = dist_rdata;
                state_next = S_EDGE;
                if (alu_res.lt)
                begin
                    dist_we    = 1'b1;
                    dist_waddr = v_reg;
                    dist_wdata = sum_reg;
                    if (hfill_reg >= HIDX_W'(HEAP_DEPTH))
                    begin
                        run_status_next = ST_FULL;
                    end
                    else
                    begin
                        idx_next   = hfill_reg;
                        hfill_next = hfill_reg + HIDX_W'(1);
                        x_next     = '{key: sum_reg, vertex: v_reg};
                        state_next = S_SU;
                    end
                end
            end
            S_SU:
            begin
                par_next   = (idx_reg - HIDX_W'(1)) >> 1;
                heap_raddr = (idx_reg - HIDX_W'(1)) >> 1;
                if (idx_reg == '0)
                begin
                    heap_we    = 1'b1;
                    state_next = S_EDGE;
                end
                else
                begin
                    state_next = S_SU1;
                end
            end
            S_SU1:
            begin
                // parent moves down while its key is larger
                alu_a   = x_reg.key;
                alu_b   = heap_rdata.key;
                heap_we = 1'b1;
                if (alu_res.lt)
                begin
                    heap_wdata = heap_rdata;
                    idx_next   = par_reg;
                    state_next = S_SU;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            vcount_reg     <= CNT_W'(MAX_VERTICES);
            rev_reg        <= 1'b0;
            efill_reg      <= '0;
            hfill_reg      <= '0;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
            run_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            rev_reg        <= rev_next;
            efill_reg      <= efill_next;
            hfill_reg      <= hfill_next;
            sweep_reg      <= sweep_next;
            out_valid_reg  <= out_valid_next;
            run_status_reg <= run_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        out_reg  <= out_next;
        cost_reg <= cost_next;
        u_reg    <= u_next;
        x_reg    <= x_next;
        idx_reg  <= idx_next;
        lent_reg <= lent_next;
        llt_reg  <= llt_next;
        link_reg <= link_next;
        sum_reg  <= sum_next;
        v_reg    <= v_next;
        par_reg  <= par_next;
    end

`ifndef NO_ASSERTIONS
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hfill_reg <= HIDX_W'(HEAP_DEPTH))
        else $error("heap fill beyond depth");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        efill_reg <= LINK_W'(MAX_EDGES))
        else $error("edge fill beyond table size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL
                       || rsp.status == ST_RANGE))
        else $error("bad status code");
`endif

endmodule
`default_nettype wire
